// ----- src/gsa_pkg.sv -----
package gsa_pkg;

  // Handle field widths and slot range
  localparam int IDX_W      = 8;
  localparam int GEN_W      = 8;
  localparam int MAX_INDEX  = 255;
  localparam int SLOT_COUNT = MAX_INDEX + 1;
  localparam int FRESH_W    = IDX_W + 1;

  // Operation codes
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_INVALID = 2'd2;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // One request item
  typedef struct packed {
    logic [1:0]       operation;
    logic [IDX_W-1:0] handle_index;
    logic [GEN_W-1:0] handle_generation;
  } req_t;

  // One result item
  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted_index;
    logic [GEN_W-1:0] granted_generation;
    logic [IDX_W-1:0] live_total;
    logic [IDX_W-1:0] free_total;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

endpackage

// ----- src/generational_slot_allocator.sv -----
// A start accepted in idle loads the item; exec commits it, and done and result are registered from exec.
// Each item reads the slot tables once and writes them back once; busy is high during the
// write-back (exec) state, and start is not taken until the controller is idle again.
// The receiver cannot stall; done is high for one cycle per result, and result holds it until the next commit.
// Reset (rst, synchronous): free list empty, counters zero, fresh index 1, done low; slot tables are not reset.
module generational_slot_allocator (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  gsa_pkg::req_t  request,
  output logic           done,
  output gsa_pkg::rsp_t  result
);

  gsa_pkg::ctl_cmd_t cmd;

  gsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  gsa_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .done    (done),
    .result  (result)
  );

endmodule

// ----- src/gsa_ctrl.sv -----
module gsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output gsa_pkg::ctl_cmd_t   cmd
);

  gsa_pkg::state_t state;
  gsa_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands: load reads the tables, exec commits
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      gsa_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = gsa_pkg::ST_EXEC;
        end
      end
      gsa_pkg::ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = gsa_pkg::ST_IDLE;
      end
      default: begin
        state_next = gsa_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state == gsa_pkg::ST_EXEC);

endmodule

// ----- src/gsa_datapath.sv -----
module gsa_datapath (
  input  logic               clk,
  input  logic               rst,
  input  gsa_pkg::ctl_cmd_t  cmd,
  input  gsa_pkg::req_t      request,
  output logic               done,
  output gsa_pkg::rsp_t      result
);

  localparam int IW = gsa_pkg::IDX_W;
  localparam int GW = gsa_pkg::GEN_W;
  localparam int FW = gsa_pkg::FRESH_W;
  localparam int SC = gsa_pkg::SLOT_COUNT;

  // Slot tables; entries of unissued slots are never consulted
  logic          slot_live [SC];
  logic [GW-1:0] gen_mem [SC];
  logic [IW-1:0] link_mem [SC];

  // List and counters
  logic [IW-1:0] head, tail;
  logic [FW-1:0] next_fresh;
  logic [IW-1:0] live_tally, free_tally;

  // Captured item and table reads
  logic [1:0]    op_q;
  logic [IW-1:0] idx_q;
  logic [GW-1:0] gen_q;
  logic          live_rd;
  logic [GW-1:0] gen_rd;
  logic [IW-1:0] link_rd;
  logic [IW-1:0] rd_addr;

  // Commit-side signals
  logic [IW-1:0] head_next, tail_next;
  logic [FW-1:0] next_fresh_next;
  logic [IW-1:0] live_tally_next, free_tally_next;
  logic          live_we, live_wd;
  logic [IW-1:0] live_wa;
  logic          gen_we;
  logic [IW-1:0] gen_wa;
  logic [GW-1:0] gen_wd;
  logic          link_we;
  logic [IW-1:0] link_wa;
  logic [IW-1:0] link_wd;
  logic          handle_ok;
  gsa_pkg::rsp_t rsp_next;

  // Allocate reads at the list head, the others at the handle's slot
  assign rd_addr = (request.operation == gsa_pkg::OP_ALLOC) ? head : request.handle_index;

  // Capture item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= request.operation;
      idx_q   <= request.handle_index;
      gen_q   <= request.handle_generation;
    end
  end

  // Live flag table
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      live_rd <= slot_live[rd_addr];
    end
    if (cmd.exec && live_we) begin
      slot_live[live_wa] <= live_wd;
    end
  end

  // Generation table
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gen_rd <= gen_mem[rd_addr];
    end
    if (cmd.exec && gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
  end

  // Free-list link table
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      link_rd <= link_mem[head];
    end
    if (cmd.exec && link_we) begin
      link_mem[link_wa] <= link_wd;
    end
  end

  assign handle_ok = (idx_q != '0) && ({1'b0, idx_q} < next_fresh) && live_rd &&
                     (gen_rd == gen_q);

  // Operation decode and state update
  always_comb begin
    head_next       = head;
    tail_next       = tail;
    next_fresh_next = next_fresh;
    live_tally_next = live_tally;
    free_tally_next = free_tally;
    live_we         = 1'b0;
    live_wa         = idx_q;
    live_wd         = 1'b0;
    gen_we          = 1'b0;
    gen_wa          = idx_q;
    gen_wd          = gen_rd + GW'(1);
    link_we         = 1'b0;
    link_wa         = tail;
    link_wd         = idx_q;
    rsp_next        = '0;
    rsp_next.status = gsa_pkg::STS_OK;
    case (op_q)
      gsa_pkg::OP_ALLOC: begin
        if (head != '0) begin
          // reuse oldest freed slot; a lone entry empties the list
          head_next                   = (head == tail) ? '0 : link_rd;
          tail_next                   = (head == tail) ? '0 : tail;
          live_we                     = 1'b1;
          live_wa                     = head;
          live_wd                     = 1'b1;
          rsp_next.granted_index      = head;
          rsp_next.granted_generation = gen_rd;
          free_tally_next             = free_tally - IW'(1);
          live_tally_next             = live_tally + IW'(1);
        end else if (next_fresh <= FW'(gsa_pkg::MAX_INDEX)) begin
          // fresh slot at generation zero
          next_fresh_next        = next_fresh + FW'(1);
          live_we                = 1'b1;
          live_wa                = next_fresh[IW-1:0];
          live_wd                = 1'b1;
          gen_we                 = 1'b1;
          gen_wa                 = next_fresh[IW-1:0];
          gen_wd                 = '0;
          rsp_next.granted_index = next_fresh[IW-1:0];
          live_tally_next        = live_tally + IW'(1);
        end else begin
          rsp_next.status = gsa_pkg::STS_FULL;
        end
      end
      gsa_pkg::OP_FREE: begin
        if (handle_ok) begin
          live_we = 1'b1;
          gen_we  = 1'b1;
          // append at tail
          if (tail == '0) begin
            head_next = idx_q;
          end else begin
            link_we = 1'b1;
          end
          tail_next       = idx_q;
          live_tally_next = live_tally - IW'(1);
          free_tally_next = free_tally + IW'(1);
        end else begin
          rsp_next.status = gsa_pkg::STS_INVALID;
        end
      end
      gsa_pkg::OP_LOOKUP: begin
        if (handle_ok) begin
          rsp_next.granted_index      = idx_q;
          rsp_next.granted_generation = gen_rd;
        end else begin
          rsp_next.status = gsa_pkg::STS_INVALID;
        end
      end
      default: begin
        rsp_next.status = gsa_pkg::STS_INVALID;
      end
    endcase
    rsp_next.live_total = live_tally_next;
    rsp_next.free_total = free_tally_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      next_fresh <= FW'(1);
      live_tally <= '0;
      free_tally <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        head       <= head_next;
        tail       <= tail_next;
        next_fresh <= next_fresh_next;
        live_tally <= live_tally_next;
        free_tally <= free_tally_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Every issued slot is either live or on the free list
  a_tally_sum: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, live_tally} + {1'b0, free_tally}) == (next_fresh - FW'(1)))
    else $error("live and free tallies do not cover issued slots");

  // Head and tail are empty together
  a_list_ends: assert property (@(posedge clk) disable iff (rst)
    (head == '0) == (tail == '0))
    else $error("free list head and tail disagree on empty");

  // Empty list exactly when the free tally is zero
  a_list_tally: assert property (@(posedge clk) disable iff (rst)
    (head == '0) == (free_tally == '0))
    else $error("free list emptiness and free tally disagree");

  // Full is reported only with no slot left anywhere
  a_full: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == gsa_pkg::STS_FULL) |->
      (head == '0) && (next_fresh == FW'(gsa_pkg::MAX_INDEX + 1)))
    else $error("full reported while a slot was available");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  // Operation code the block must reject
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 6;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  gsa_pkg::req_t request;
  gsa_pkg::rsp_t result;

  generational_slot_allocator DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // Shadow copy of the allocator state
  bit                        shadow_live [gsa_pkg::SLOT_COUNT];
  logic [gsa_pkg::GEN_W-1:0] shadow_gen  [gsa_pkg::SLOT_COUNT];
  logic [gsa_pkg::IDX_W-1:0] shadow_link [gsa_pkg::SLOT_COUNT];
  logic [gsa_pkg::IDX_W-1:0] shadow_head;
  logic [gsa_pkg::IDX_W-1:0] shadow_tail;
  logic [gsa_pkg::FRESH_W-1:0] shadow_fresh;
  logic [gsa_pkg::IDX_W-1:0] shadow_live_cnt;
  logic [gsa_pkg::IDX_W-1:0] shadow_free_cnt;

  gsa_pkg::rsp_t pending_grants[$];
  gsa_pkg::rsp_t oldest_grant;
  int   error_count;
  int   cycle_count;
  bit   idle_enable;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding",
               cycle_count, pending_grants.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 40) $display("[%0t] MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic bit handle_matches(logic [gsa_pkg::IDX_W-1:0] idx,
                                        logic [gsa_pkg::GEN_W-1:0] gen);
    return idx != '0 && {1'b0, idx} < shadow_fresh && shadow_live[idx] &&
           shadow_gen[idx] == gen;
  endfunction

  // Predict one grant and advance the shadow state
  function automatic gsa_pkg::rsp_t predict_grant(gsa_pkg::req_t r);
    gsa_pkg::rsp_t g;
    logic [gsa_pkg::IDX_W-1:0] s;
    g = '0;
    g.status = gsa_pkg::STS_OK;
    case (r.operation)
      gsa_pkg::OP_ALLOC: begin
        if (shadow_head != '0) begin
          s = shadow_head;
          shadow_head = shadow_link[s];
          shadow_link[s] = '0;
          if (shadow_head == '0) shadow_tail = '0;
          shadow_live[s] = 1'b1;
          g.granted_index = s;
          g.granted_generation = shadow_gen[s];
          shadow_free_cnt = shadow_free_cnt - gsa_pkg::IDX_W'(1);
          shadow_live_cnt = shadow_live_cnt + gsa_pkg::IDX_W'(1);
        end else if (shadow_fresh <= gsa_pkg::FRESH_W'(gsa_pkg::MAX_INDEX)) begin
          s = shadow_fresh[gsa_pkg::IDX_W-1:0];
          shadow_fresh = shadow_fresh + gsa_pkg::FRESH_W'(1);
          shadow_live[s] = 1'b1;
          shadow_gen[s] = '0;
          g.granted_index = s;
          shadow_live_cnt = shadow_live_cnt + gsa_pkg::IDX_W'(1);
        end else begin
          g.status = gsa_pkg::STS_FULL;
        end
      end
      gsa_pkg::OP_FREE: begin
        if (handle_matches(r.handle_index, r.handle_generation)) begin
          s = r.handle_index;
          shadow_live[s] = 1'b0;
          shadow_gen[s] = shadow_gen[s] + gsa_pkg::GEN_W'(1);
          shadow_link[s] = '0;
          if (shadow_tail == '0) shadow_head = s;
          else shadow_link[shadow_tail] = s;
          shadow_tail = s;
          shadow_live_cnt = shadow_live_cnt - gsa_pkg::IDX_W'(1);
          shadow_free_cnt = shadow_free_cnt + gsa_pkg::IDX_W'(1);
        end else begin
          g.status = gsa_pkg::STS_INVALID;
        end
      end
      gsa_pkg::OP_LOOKUP: begin
        if (handle_matches(r.handle_index, r.handle_generation)) begin
          g.granted_index = r.handle_index;
          g.granted_generation = shadow_gen[r.handle_index];
        end else begin
          g.status = gsa_pkg::STS_INVALID;
        end
      end
      default: g.status = gsa_pkg::STS_INVALID;
    endcase
    g.live_total = shadow_live_cnt;
    g.free_total = shadow_free_cnt;
    return g;
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("result strobe with no item outstanding");
      end else begin
        oldest_grant = pending_grants.pop_front();
        check_field("status", 8'(result.status), 8'(oldest_grant.status));
        check_field("granted_index", result.granted_index, oldest_grant.granted_index);
        check_field("granted_generation", result.granted_generation,
                    oldest_grant.granted_generation);
        check_field("live_total", result.live_total, oldest_grant.live_total);
        check_field("free_total", result.free_total, oldest_grant.free_total);
      end
    end
  end

  function automatic gsa_pkg::req_t make_req(logic [1:0] op,
                                             logic [gsa_pkg::IDX_W-1:0] idx,
                                             logic [gsa_pkg::GEN_W-1:0] gen);
    gsa_pkg::req_t r;
    r.operation = op;
    r.handle_index = idx;
    r.handle_generation = gen;
    return r;
  endfunction

  // Send one item; start stays high until someone drops it
  task automatic send_item(input gsa_pkg::req_t r);
    @(negedge clk);
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    pending_grants = {pending_grants, predict_grant(r)};
  endtask

  // Random sender gap: when enabled, one item in four on average drops start and idles
  task automatic maybe_idle();
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
  endtask

  task automatic send_paced(input gsa_pkg::req_t r);
    send_item(r);
    maybe_idle();
  endtask

  // Hold off until every outstanding item has returned
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Find some live handle, scanning from a random slot
  function automatic bit pick_live_handle(output logic [gsa_pkg::IDX_W-1:0] idx,
                                          output logic [gsa_pkg::GEN_W-1:0] gen);
    int base;
    int k;
    base = $urandom_range(1, gsa_pkg::MAX_INDEX);
    for (k = 0; k < gsa_pkg::MAX_INDEX; k++) begin
      idx = gsa_pkg::IDX_W'(((base - 1 + k) % gsa_pkg::MAX_INDEX) + 1);
      if (shadow_live[idx]) begin
        gen = shadow_gen[idx];
        return 1'b1;
      end
    end
    idx = gsa_pkg::IDX_W'($urandom);
    gen = gsa_pkg::GEN_W'($urandom);
    return 1'b0;
  endfunction

  // Null, unissued, dead, stale handles and the undefined operation
  task automatic test_bad_handles();
    send_paced(make_req(gsa_pkg::OP_LOOKUP, 8'd0, 8'd0));
    send_paced(make_req(gsa_pkg::OP_FREE, 8'd0, 8'd0));
    send_paced(make_req(gsa_pkg::OP_LOOKUP, 8'd1, 8'd0));
    send_paced(make_req(gsa_pkg::OP_FREE, 8'hFF, 8'hFF));
    send_paced(make_req(OP_UNDEFINED, 8'hAA, 8'h55));
    send_paced(make_req(gsa_pkg::OP_ALLOC, 8'hFF, 8'hFF));
    send_paced(make_req(gsa_pkg::OP_LOOKUP, 8'd1, 8'd0));
    send_paced(make_req(gsa_pkg::OP_LOOKUP, 8'd1, 8'h80));
    send_paced(make_req(gsa_pkg::OP_LOOKUP, 8'd2, 8'd0));
    send_paced(make_req(gsa_pkg::OP_FREE, 8'd1, 8'd1));
    send_paced(make_req(gsa_pkg::OP_FREE, 8'd1, 8'd0));
    send_paced(make_req(gsa_pkg::OP_FREE, 8'd1, 8'd0));
    send_paced(make_req(gsa_pkg::OP_LOOKUP, 8'd1, 8'd1));
    send_paced(make_req(gsa_pkg::OP_ALLOC, 8'd0, 8'd0));
    send_paced(make_req(gsa_pkg::OP_LOOKUP, 8'd1, 8'd1));
    send_paced(make_req(OP_UNDEFINED, 8'hFF, 8'hFF));
  endtask

  // Freed slots come back in the order they were freed
  task automatic test_round_robin_reuse();
    repeat (3) send_paced(make_req(gsa_pkg::OP_ALLOC, 8'd0, 8'd0));
    send_paced(make_req(gsa_pkg::OP_FREE, 8'd3, 8'd0));
    send_paced(make_req(gsa_pkg::OP_FREE, 8'd2, 8'd0));
    send_paced(make_req(gsa_pkg::OP_FREE, 8'd4, 8'd0));
    repeat (3) send_paced(make_req(gsa_pkg::OP_ALLOC, 8'd0, 8'd0));
    send_paced(make_req(gsa_pkg::OP_LOOKUP, 8'd4, 8'd1));
  endtask

  // Use up every index, then allocate past the end
  task automatic test_exhaustion();
    drain();
    while (shadow_fresh <= gsa_pkg::FRESH_W'(gsa_pkg::MAX_INDEX) || shadow_head != '0)
      send_paced(make_req(gsa_pkg::OP_ALLOC, gsa_pkg::IDX_W'($urandom),
                          gsa_pkg::GEN_W'($urandom)));
    send_paced(make_req(gsa_pkg::OP_ALLOC, 8'd0, 8'd0));
    send_paced(make_req(gsa_pkg::OP_ALLOC, 8'hFF, 8'hFF));
    send_paced(make_req(gsa_pkg::OP_LOOKUP, 8'hFF, 8'd0));
    send_paced(make_req(gsa_pkg::OP_LOOKUP, 8'hFF, 8'hFF));
  endtask

  // Cycle one slot through free and alloc until its generation wraps
  task automatic test_generation_wrap();
    logic [gsa_pkg::IDX_W-1:0] slot;
    slot = gsa_pkg::IDX_W'($urandom_range(1, gsa_pkg::MAX_INDEX));
    repeat (257) begin
      send_paced(make_req(gsa_pkg::OP_FREE, slot, shadow_gen[slot]));
      send_paced(make_req(gsa_pkg::OP_ALLOC, 8'd0, 8'd0));
      if (shadow_gen[slot] == 8'hFF || shadow_gen[slot] == 8'h00)
        send_paced(make_req(gsa_pkg::OP_LOOKUP, slot, shadow_gen[slot]));
    end
  endtask

  // Random traffic in phases of varying alloc pressure
  task automatic test_random_traffic();
    int alloc_pct [10] = '{90, 20, 10, 10, 80, 95, 50, 5, 90, 50};
    int ph;
    int roll;
    logic [gsa_pkg::IDX_W-1:0] idx;
    logic [gsa_pkg::GEN_W-1:0] gen;
    logic [1:0] op;
    for (ph = 0; ph < 10; ph++) begin
      idle_enable = (ph < 8) && ($urandom_range(0, 4) != 0);
      repeat (70) begin
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct[ph]) begin
          send_paced(make_req(gsa_pkg::OP_ALLOC, gsa_pkg::IDX_W'($urandom),
                              gsa_pkg::GEN_W'($urandom)));
        end else begin
          roll = $urandom_range(0, 9);
          void'(pick_live_handle(idx, gen));
          op = ($urandom_range(0, 1) != 0) ? gsa_pkg::OP_FREE : gsa_pkg::OP_LOOKUP;
          if (roll < 5) begin
            send_paced(make_req(gsa_pkg::OP_FREE, idx, gen));
          end else if (roll < 8) begin
            send_paced(make_req(gsa_pkg::OP_LOOKUP, idx, gen));
          end else if (roll == 8) begin
            // stale generation on a live slot
            send_paced(make_req(op, idx,
                                gen ^ gsa_pkg::GEN_W'(1 << $urandom_range(0, 7))));
          end else begin
            send_paced(make_req(2'($urandom), gsa_pkg::IDX_W'($urandom),
                                gsa_pkg::GEN_W'($urandom)));
          end
        end
      end
      if (ph == 3 || ph == 7) drain();
    end
  endtask

  // Main sequence
  initial begin
    error_count = 0;
    idle_enable = 1'b1;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    foreach (shadow_live[i]) begin
      shadow_live[i] = 1'b0;
      shadow_gen[i] = '0;
      shadow_link[i] = '0;
    end
    shadow_head = '0;
    shadow_tail = '0;
    shadow_fresh = gsa_pkg::FRESH_W'(1);
    shadow_live_cnt = '0;
    shadow_free_cnt = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_bad_handles();
    test_round_robin_reuse();
    test_exhaustion();
    test_generation_wrap();
    test_random_traffic();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_grants.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
